// File: hw/rtl/vmb_pkg.sv
`timescale 1ns / 1ps
package vmb_pkg;
	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ_LO = 2'd1,
		OP_READ_HI = 2'd2,
		OP_STATUS  = 2'd3
	} op_t;

	// Command classes decided by the front end.
	typedef enum logic [3:0] {
		K_NONE,
		K_READ_LO,
		K_READ_HI,
		K_LOAD_LO,
		K_LOAD_HI,
		K_LOAD_CNT,
		K_SHOW,
		K_MUL_SUB,
		K_MUL_FIRST,
		K_MUL_SECOND,
		K_DIV_98,
		K_DIV_AB,
		K_WINDOW,
		K_DIST_ABS,
		K_DIST
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] reg_idx;
		logic [7:0] data;
	} cmd_t;

	localparam int QDEPTH = 2;
endpackage

// File: hw/rtl/vmb_if.sv
`timescale 1ns / 1ps
interface vmb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [4:0] offset;
	logic [7:0] data;
	modport source (output valid, operation, offset, data, input ready);
	modport sink (input valid, operation, offset, data, output ready);
endinterface

interface vmb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

// File: hw/rtl/vector_math_box_core.sv
`timescale 1ns / 1ps
// Loads, reads and status go straight to the reply register; a rotation pair, a distance,
// the window clip and a division run through the back-end states first, and the second or
// first rotation product can run on into the division.
// Throughput: one request at a time in the back end, which also waits for the reply register
// to free up; up to two requests wait in the queue ahead of it.
// Reset: arst_n clears scratch registers, the result word, queue and state.
module vector_math_box_core import vmb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	vmb_in_if.sink     in_ch,
	vmb_out_if.source  out_ch
);
	// The front end decodes each request into a command and queues it.
	logic q_valid, q_ready;
	cmd_t q_cmd;

	vmb_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	// The back end runs the command over as many cycles as it needs and
	// holds its one-byte reply in an output register.
	vmb_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.out_ch(out_ch)
	);

	// A held reply keeps its byte until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.read_data))
		else $error("reply changed while stalled");
	// A command is only taken while queued.
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready && !q_valid |=> !$rose(out_ch.valid))
		else $error("reply without command");
endmodule

// File: hw/rtl/vmb_front.sv
`timescale 1ns / 1ps
module vmb_front import vmb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	vmb_in_if.sink       in_ch,
	output logic         q_valid,
	input  logic         q_ready,
	output cmd_t         q_cmd
);
	cmd_t c;

	always_comb begin
		c.kind = K_NONE;
		c.reg_idx = 4'd0;
		c.data = in_ch.data;
		case (op_t'(in_ch.operation))
			OP_READ_LO: c.kind = K_READ_LO;
			OP_READ_HI: c.kind = K_READ_HI;
			OP_WRITE: begin
				case (in_ch.offset)
					5'h00: begin c.kind = K_LOAD_LO; c.reg_idx = 4'd0; end
					5'h01: begin c.kind = K_LOAD_HI; c.reg_idx = 4'd0; end
					5'h02: begin c.kind = K_LOAD_LO; c.reg_idx = 4'd1; end
					5'h03: begin c.kind = K_LOAD_HI; c.reg_idx = 4'd1; end
					5'h04: begin c.kind = K_LOAD_LO; c.reg_idx = 4'd2; end
					5'h05: begin c.kind = K_LOAD_HI; c.reg_idx = 4'd2; end
					5'h06: begin c.kind = K_LOAD_LO; c.reg_idx = 4'd3; end
					5'h07: begin c.kind = K_LOAD_HI; c.reg_idx = 4'd3; end
					5'h08: begin c.kind = K_LOAD_LO; c.reg_idx = 4'd4; end
					5'h09: begin c.kind = K_LOAD_HI; c.reg_idx = 4'd4; end
					5'h0a: begin c.kind = K_LOAD_LO; c.reg_idx = 4'd5; end
					5'h0b: c.kind = K_MUL_SUB;
					5'h0c: c.kind = K_LOAD_CNT;
					5'h0d: begin c.kind = K_LOAD_LO; c.reg_idx = 4'd10; end
					5'h0e: begin c.kind = K_LOAD_HI; c.reg_idx = 4'd10; end
					5'h0f: begin c.kind = K_LOAD_LO; c.reg_idx = 4'd11; end
					5'h10: begin c.kind = K_LOAD_HI; c.reg_idx = 4'd11; end
					5'h11: c.kind = K_MUL_FIRST;
					5'h12: c.kind = K_MUL_SECOND;
					5'h13: c.kind = K_DIV_98;
					5'h14: c.kind = K_DIV_AB;
					5'h15: begin c.kind = K_LOAD_LO; c.reg_idx = 4'd7; end
					5'h16: begin c.kind = K_LOAD_HI; c.reg_idx = 4'd7; end
					5'h17: begin c.kind = K_SHOW; c.reg_idx = 4'd7; end
					5'h18: begin c.kind = K_SHOW; c.reg_idx = 4'd9; end
					5'h19: begin c.kind = K_SHOW; c.reg_idx = 4'd8; end
					5'h1a: begin c.kind = K_LOAD_LO; c.reg_idx = 4'd8; end
					5'h1b: begin c.kind = K_LOAD_HI; c.reg_idx = 4'd8; end
					5'h1c: c.kind = K_WINDOW;
					5'h1d: c.kind = K_DIST_ABS;
					5'h1e: c.kind = K_DIST;
					default: c.kind = K_NONE;
				endcase
			end
			default: c.kind = K_NONE;
		endcase
	end

	// Small queue toward the execution unit.
	cmd_t       mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ch.ready = (cnt_q != 2'(QDEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= c;
	end
endmodule

// File: hw/rtl/vmb_back.sv
`timescale 1ns / 1ps
module vmb_back import vmb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	output logic         q_ready,
	input  cmd_t         q_cmd,
	vmb_out_if.source    out_ch
);
	typedef enum logic [4:0] {
		S_IDLE, S_F1, S_F2, S_F3, S_F4,
		S_S1, S_S2, S_S3, S_S4, S_S5,
		S_D0, S_DLOOP, S_DEND,
		S_W1, S_W2, S_X0, S_X1, S_X2, S_X3, S_OUT
	} st_t;

	st_t         st_q;
	logic [15:0] r_q [16];
	logic [15:0] res_q;
	logic [15:0] q_q, cnt_q;
	logic [15:0] num_q, den_q;
	logic [31:0] prod_q;
	logic [15:0] lo_q, hi_q;
	logic [7:0]  rd_q;
	logic [7:0]  byte_q;
	logic [7:0]  rbyte;
	logic        ov_q;
	logic [15:0] t14, t15;
	logic [31:0] mul_out;
	logic signed [16:0] ma, mb;
	logic signed [33:0] prod_w;
	logic [15:0] sub, r13n, cntn, qn;

	function automatic logic [15:0] hsum(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {a[15], a} + {b[15], b};
		return s[16:1];
	endfunction

	function automatic logic [15:0] ab(logic [15:0] v);
		return v[15] ? 16'(16'd0 - v) : v;
	endfunction

	// One shared multiplier, operands chosen by state. Operands are 17 bits so
	// that negating r1 keeps the magnitude of -32768.
	always_comb begin
		ma = {r_q[0][15], r_q[0]};
		mb = {r_q[4][15], r_q[4]};
		case (st_q)
			S_F1: begin ma = {r_q[0][15], r_q[0]}; mb = {r_q[4][15], r_q[4]}; end
			S_F2: begin
				ma = 17'(17'sd0 - $signed({r_q[1][15], r_q[1]}));
				mb = {r_q[5][15], r_q[5]};
			end
			S_S1: begin ma = {r_q[1][15], r_q[1]}; mb = {r_q[4][15], r_q[4]}; end
			S_S2: begin ma = {r_q[0][15], r_q[0]}; mb = {r_q[5][15], r_q[5]}; end
			default: ;
		endcase
		prod_w = ma * mb;
	end
	assign mul_out = prod_w[31:0];

	// Byte that a read returns; writes and status reads return zero.
	always_comb begin
		case (q_cmd.kind)
			K_READ_LO: rbyte = res_q[7:0];
			K_READ_HI: rbyte = res_q[15:8];
			default:   rbyte = 8'd0;
		endcase
	end

	assign t14 = hsum(r_q[4], r_q[7]);
	assign t15 = hsum(r_q[5], r_q[8]);
	assign sub = 16'(r_q[13] - r_q[12]);
	assign r13n = sub[15] ? {r_q[13][14:0], q_q[15]} : {sub[14:0], q_q[15]};
	assign qn = {q_q[14:0], ~sub[15]};
	assign cntn = 16'(cnt_q - 16'd1);

	assign q_ready = (st_q == S_IDLE);
	assign out_ch.valid = ov_q;
	assign out_ch.read_data = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ov_q <= 1'b0;
			res_q <= 16'd0;
			rd_q <= 8'd0;
			byte_q <= 8'd0;
			for (int i = 0; i < 16; i++) r_q[i] <= 16'd0;
			q_q <= 16'd0; cnt_q <= 16'd0; num_q <= 16'd0; den_q <= 16'd0;
			prod_q <= 32'd0; lo_q <= 16'd0; hi_q <= 16'd0;
		end else begin
			if (out_ch.valid && out_ch.ready && st_q != S_OUT) ov_q <= 1'b0;
			case (st_q)
				S_IDLE: if (q_valid) begin
					byte_q <= rbyte;
					st_q <= S_OUT;
					case (q_cmd.kind)
						K_LOAD_LO: begin
							r_q[q_cmd.reg_idx] <= {r_q[q_cmd.reg_idx][15:8], q_cmd.data};
							res_q <= {r_q[q_cmd.reg_idx][15:8], q_cmd.data};
						end
						K_LOAD_HI: begin
							r_q[q_cmd.reg_idx] <= {q_cmd.data, r_q[q_cmd.reg_idx][7:0]};
							res_q <= {q_cmd.data, r_q[q_cmd.reg_idx][7:0]};
						end
						K_LOAD_CNT: begin
							r_q[6] <= {8'd0, q_cmd.data};
							res_q <= {8'd0, q_cmd.data};
						end
						K_SHOW: res_q <= r_q[q_cmd.reg_idx];
						K_MUL_SUB: begin
							r_q[15] <= 16'hffff;
							r_q[4] <= 16'(r_q[4] - r_q[2]);
							r_q[5] <= 16'({q_cmd.data, r_q[5][7:0]} - r_q[3]);
							st_q <= S_F1;
						end
						K_MUL_FIRST: begin
							r_q[15] <= 16'd0;
							r_q[5] <= {q_cmd.data, r_q[5][7:0]};
							st_q <= S_F1;
						end
						K_MUL_SECOND: st_q <= S_S1;
						K_DIV_98: begin num_q <= r_q[9]; den_q <= r_q[8]; st_q <= S_D0; end
						K_DIV_AB: begin num_q <= r_q[10]; den_q <= r_q[11]; st_q <= S_D0; end
						K_WINDOW: begin
							r_q[5] <= {q_cmd.data, r_q[5][7:0]};
							st_q <= S_W1;
						end
						K_DIST_ABS: begin
							r_q[2] <= ab(16'(r_q[2] - r_q[0]));
							r_q[3] <= ab(16'({q_cmd.data, r_q[3][7:0]} - r_q[1]));
							st_q <= S_X0;
						end
						K_DIST: st_q <= S_X0;
						default: ;
					endcase
				end
				S_F1: begin prod_q <= mul_out; st_q <= S_F2; end
				S_F2: begin
					r_q[12] <= prod_q[31:16];
					r_q[14] <= {1'b0, prod_q[15:1]};
					lo_q <= mul_out[15:0];
					hi_q <= mul_out[31:16];
					st_q <= S_F3;
				end
				S_F3: begin
					r_q[12] <= {1'b0, lo_q[15:1]};
					r_q[7] <= 16'(hi_q + r_q[12] +
						16'(({1'b0, lo_q[15:1]} + r_q[14]) >> 15));
					st_q <= S_F4;
				end
				S_F4: begin
					res_q <= r_q[7];
					if (r_q[15][15]) st_q <= S_OUT;
					else begin
						r_q[7] <= 16'(r_q[7] + r_q[2]);
						st_q <= S_S1;
					end
				end
				S_S1: begin prod_q <= mul_out; st_q <= S_S2; end
				S_S2: begin
					r_q[12] <= prod_q[31:16];
					r_q[9] <= {1'b0, prod_q[15:1]};
					lo_q <= mul_out[15:0];
					hi_q <= mul_out[31:16];
					st_q <= S_S3;
				end
				S_S3: begin
					r_q[12] <= {1'b0, lo_q[15:1]};
					hi_q <= 16'(hi_q + r_q[12]);
					r_q[9] <= 16'(r_q[9] + {1'b0, lo_q[15:1]});
					st_q <= S_S4;
				end
				S_S4: begin
					r_q[8] <= 16'(hi_q + 16'(r_q[9][15]));
					r_q[9] <= {r_q[9][14:0], 1'b0};
					res_q <= 16'(hi_q + 16'(r_q[9][15]));
					st_q <= S_S5;
				end
				S_S5: begin
					if (r_q[15][15]) st_q <= S_OUT;
					else begin
						r_q[8] <= 16'(r_q[8] + r_q[3]);
						r_q[9] <= {r_q[9][15:8], 8'd0};
						num_q <= {r_q[9][15:8], 8'd0};
						den_q <= 16'(r_q[8] + r_q[3]);
						st_q <= S_D0;
					end
				end
				// Division setup; den_q is the dividend high word, num_q the low.
				S_D0: begin
					r_q[14] <= r_q[7] ^ den_q;
					if (!den_q[15]) begin
						r_q[13] <= den_q;
						q_q <= num_q;
					end else begin
						r_q[13] <= ($signed(~num_q) < -16'sd1) ? 16'(~den_q + 16'd1) : ~den_q;
						q_q <= 16'(~num_q + 16'd1);
					end
					r_q[12] <= ab(r_q[7]);
					cnt_q <= r_q[6];
					st_q <= S_DLOOP;
				end
				S_DLOOP: begin
					r_q[13] <= r13n;
					q_q <= qn;
					cnt_q <= cntn;
					if (cntn[15]) st_q <= S_DEND;
				end
				S_DEND: begin
					r_q[15] <= cnt_q;
					res_q <= r_q[14][15] ? 16'(16'd0 - q_q) : q_q;
					st_q <= S_OUT;
				end
				S_W1: begin
					r_q[14] <= t14;
					r_q[15] <= t15;
					if ($signed(r_q[11]) < $signed(t14) && $signed(t15) < $signed(t14) &&
						($signed({t14[15], t14}) + $signed({t15[15], t15})) >= 0) begin
						r_q[7] <= t14;
						r_q[8] <= t15;
					end else begin
						r_q[4] <= t14;
						r_q[5] <= t15;
					end
					r_q[6] <= 16'(r_q[6] - 16'd1);
					// The loop ends once the decremented count turns negative.
					if (r_q[6] == 16'd0 || (r_q[6][15] && r_q[6] != 16'h8000)) st_q <= S_W2;
				end
				S_W2: begin res_q <= r_q[8]; st_q <= S_OUT; end
				S_X0: begin
					if ($signed(r_q[3]) >= $signed(r_q[2])) begin
						lo_q <= r_q[2]; hi_q <= r_q[3];
					end else begin
						lo_q <= r_q[3]; hi_q <= r_q[2];
					end
					st_q <= S_X1;
				end
				S_X1: begin
					hi_q <= 16'(hi_q + {{2{lo_q[15]}}, lo_q[15:2]});
					lo_q <= {{2{lo_q[15]}}, lo_q[15:2]};
					st_q <= S_X2;
				end
				S_X2: begin
					hi_q <= 16'(hi_q + {lo_q[15], lo_q[15:1]});
					lo_q <= {lo_q[15], lo_q[15:1]};
					st_q <= S_X3;
				end
				S_X3: begin
					r_q[12] <= lo_q;
					r_q[13] <= hi_q;
					res_q <= hi_q;
					st_q <= S_OUT;
				end
				S_OUT: if (!ov_q || out_ch.ready) begin
					ov_q <= 1'b1;
					rd_q <= byte_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: tb/vmb_checker.sv
`timescale 1ns / 1ps
module vmb_checker import vmb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  in_operation,
	input  logic [4:0]  in_offset,
	input  logic [7:0]  in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_read_data,
	output int          errors,
	output int          pending
);
	logic [15:0] sreg [16];
	logic [15:0] result;
	logic [7:0] bytes_due [$];

	function automatic bit is_neg(logic [15:0] v);
		return v[15];
	endfunction

	function automatic logic [15:0] halve(logic [15:0] a, logic [15:0] b);
		logic signed [16:0] s;
		s = $signed({a[15], a}) + $signed({b[15], b});
		return s[16:1];
	endfunction

	function automatic logic [15:0] magnitude(logic [15:0] v);
		return v[15] ? 16'(-v) : v;
	endfunction

	// Restoring division with sign correction; the count register wraps at 16 bits.
	task automatic run_divide(logic [15:0] num_lo, logic [15:0] q);
		logic [15:0] cnt;
		logic msb;
		sreg[14] = sreg[7] ^ q;
		sreg[13] = q;
		if (!is_neg(q)) begin
			q = num_lo;
		end else begin
			sreg[13] = ~q;
			q = ~num_lo;
			if ($signed(q) < -1)
				sreg[13] = sreg[13] + 16'd1;
			q = q + 16'd1;
		end
		sreg[12] = magnitude(sreg[7]);
		cnt = sreg[6];
		do begin
			sreg[13] = sreg[13] - sreg[12];
			msb = q[15];
			q = q << 1;
			if (!is_neg(sreg[13]))
				q = q + 16'd1;
			else
				sreg[13] = sreg[13] + sreg[12];
			sreg[13] = (sreg[13] << 1) + 16'(msb);
			cnt = cnt - 16'd1;
		end while (!is_neg(cnt));
		sreg[15] = cnt;
		result = is_neg(sreg[14]) ? 16'(-q) : q;
	endtask

	task automatic run_second();
		logic signed [31:0] p;
		logic [15:0] lo;
		p = $signed(sreg[1]) * $signed(sreg[4]);
		sreg[12] = p[31:16];
		sreg[9] = p[15:0];
		p = $signed(sreg[0]) * $signed(sreg[5]);
		lo = p[15:0];
		sreg[8] = p[31:16] + sreg[12];
		sreg[9] = sreg[9] >> 1;
		sreg[12] = lo >> 1;
		sreg[9] = sreg[9] + sreg[12];
		if (is_neg(sreg[9]))
			sreg[8] = sreg[8] + 16'd1;
		sreg[9] = sreg[9] << 1;
		result = sreg[8];
		if (!is_neg(sreg[15])) begin
			sreg[8] = sreg[8] + sreg[3];
			sreg[9] = sreg[9] & 16'hff00;
			run_divide(sreg[9], sreg[8]);
		end
	endtask

	task automatic run_first();
		logic signed [31:0] p;
		logic [15:0] lo, sum;
		p = $signed(sreg[0]) * $signed(sreg[4]);
		sreg[12] = p[31:16];
		sreg[14] = p[15:0];
		p = -($signed(sreg[1]) * $signed(sreg[5]));
		lo = p[15:0];
		sreg[7] = p[31:16] + sreg[12];
		sreg[14] = sreg[14] >> 1;
		sreg[12] = lo >> 1;
		sum = sreg[12] + sreg[14];
		if (is_neg(sum))
			sreg[7] = sreg[7] + 16'd1;
		result = sreg[7];
		if (!is_neg(sreg[15])) begin
			sreg[7] = sreg[7] + sreg[2];
			run_second();
		end
	endtask

	task automatic run_window();
		do begin
			sreg[14] = halve(sreg[4], sreg[7]);
			sreg[15] = halve(sreg[5], sreg[8]);
			if ($signed(sreg[11]) < $signed(sreg[14]) && $signed(sreg[15]) < $signed(sreg[14])
				&& ($signed({sreg[14][15], sreg[14]}) + $signed({sreg[15][15], sreg[15]})) >= 0) begin
				sreg[7] = sreg[14];
				sreg[8] = sreg[15];
			end else begin
				sreg[4] = sreg[14];
				sreg[5] = sreg[15];
			end
			sreg[6] = sreg[6] - 16'd1;
		end while (!is_neg(sreg[6]));
		result = sreg[8];
	endtask

	task automatic run_distance();
		logic [15:0] lo, hi;
		if ($signed(sreg[3]) >= $signed(sreg[2])) begin
			lo = sreg[2];
			hi = sreg[3];
		end else begin
			hi = sreg[2];
			lo = sreg[3];
		end
		lo = $signed(lo) >>> 2;
		hi = hi + lo;
		lo = $signed(lo) >>> 1;
		hi = hi + lo;
		sreg[12] = lo;
		sreg[13] = hi;
		result = hi;
	endtask

	task automatic load_half(int idx, bit high, logic [7:0] d);
		if (high)
			sreg[idx][15:8] = d;
		else
			sreg[idx][7:0] = d;
		result = sreg[idx];
	endtask

	task automatic apply_write(logic [4:0] off, logic [7:0] d);
		case (off)
			5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05,
			5'h06, 5'h07, 5'h08, 5'h09: load_half(int'(off[4:1]), off[0], d);
			5'h0a: load_half(5, 1'b0, d);
			5'h0c: begin
				sreg[6] = {8'h00, d};
				result = sreg[6];
			end
			5'h0d: load_half(10, 1'b0, d);
			5'h0e: load_half(10, 1'b1, d);
			5'h0f: load_half(11, 1'b0, d);
			5'h10: load_half(11, 1'b1, d);
			5'h15: load_half(7, 1'b0, d);
			5'h16: load_half(7, 1'b1, d);
			5'h17: result = sreg[7];
			5'h18: result = sreg[9];
			5'h19: result = sreg[8];
			5'h1a: load_half(8, 1'b0, d);
			5'h1b: load_half(8, 1'b1, d);
			5'h0b: begin
				sreg[5][15:8] = d;
				sreg[15] = 16'hffff;
				sreg[4] = sreg[4] - sreg[2];
				sreg[5] = sreg[5] - sreg[3];
				run_first();
			end
			5'h11: begin
				sreg[5][15:8] = d;
				sreg[15] = 16'h0000;
				run_first();
			end
			5'h12: run_second();
			5'h13: run_divide(sreg[9], sreg[8]);
			5'h14: run_divide(sreg[10], sreg[11]);
			5'h1c: begin
				sreg[5][15:8] = d;
				run_window();
			end
			5'h1d: begin
				sreg[3][15:8] = d;
				sreg[2] = magnitude(sreg[2] - sreg[0]);
				sreg[3] = magnitude(sreg[3] - sreg[1]);
				run_distance();
			end
			5'h1e: run_distance();
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			foreach (sreg[i])
				sreg[i] = '0;
			result = '0;
			bytes_due.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (bytes_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected read_data %02h, expected none", $time, out_read_data);
				end else begin
					want = bytes_due.pop_front();
					if (out_read_data !== want) begin
						errors++;
						$display("%0t: read_data expected %02h actual %02h",
							$time, want, out_read_data);
					end
				end
			end
			if (in_valid && in_ready) begin
				case (op_t'(in_operation))
					OP_WRITE: begin
						apply_write(in_offset, in_data);
						bytes_due.push_back(8'h00);
					end
					OP_READ_LO: bytes_due.push_back(result[7:0]);
					OP_READ_HI: bytes_due.push_back(result[15:8]);
					default: bytes_due.push_back(8'h00);
				endcase
			end
		end
		pending = bytes_due.size();
	end
endmodule

// File: tb/vector_math_box_core_tb.sv
`timescale 1ns / 1ps
module vector_math_box_core_tb;
	import vmb_pkg::*;

	// Command offsets used by the directed part and the random sequences.
	localparam logic [4:0] OFF_CNT      = 5'h0c;
	localparam logic [4:0] OFF_ROT_SUB  = 5'h0b;
	localparam logic [4:0] OFF_ROT      = 5'h11;
	localparam logic [4:0] OFF_ROT_2ND  = 5'h12;
	localparam logic [4:0] OFF_DIV_98   = 5'h13;
	localparam logic [4:0] OFF_DIV_AB   = 5'h14;
	localparam logic [4:0] OFF_WINDOW   = 5'h1c;
	localparam logic [4:0] OFF_DIST_ABS = 5'h1d;
	localparam logic [4:0] OFF_DIST     = 5'h1e;
	localparam logic [4:0] OFF_NOP      = 5'h1f;
	localparam int         IDLE_LIMIT   = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   quiet_cycles = 0;

	vmb_in_if  req_ch ();
	vmb_out_if rsp_ch ();

	vector_math_box_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch.sink),
		.out_ch (rsp_ch.source)
	);

	// The checker watches both channels, predicts each returned byte and
	// counts mismatches; the top only drives requests and the read side stall.
	vmb_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (req_ch.valid),
		.in_ready      (req_ch.ready),
		.in_operation  (req_ch.operation),
		.in_offset     (req_ch.offset),
		.in_data       (req_ch.data),
		.out_valid     (rsp_ch.valid),
		.out_ready     (rsp_ch.ready),
		.out_read_data (rsp_ch.read_data),
		.errors        (errors),
		.pending       (pending)
	);

	always #2 clk = ~clk;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.operation = OP_WRITE;
		req_ch.offset = '0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
	end

	// The receiver stalls in a pattern of its own: long open stretches
	// alternate with phases of light and of heavy random back-pressure.
	always @(negedge clk) begin
		int phase;
		phase = int'(($time / 2000) % 3);
		if (phase == 0)
			rsp_ch.ready <= 1'b1;
		else if (phase == 1)
			rsp_ch.ready <= ($urandom_range(0, 3) != 0);
		else
			rsp_ch.ready <= ($urandom_range(0, 3) == 0);
	end

	// Any cycle without a handshake on either channel counts toward the
	// watchdog; a hung block ends the run as a failure.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("vector_math_box_core_tb failed");
			$finish;
		end
	end

	int burst_left = 0;
	int items_sent = 0;

	// Sends one request. Between bursts the valid drops for a random gap;
	// inside a burst consecutive requests go out back to back.
	task automatic send(op_t op, logic [4:0] off, logic [7:0] d);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 6)) begin
				req_ch.valid <= 1'b0;
				@(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		items_sent++;
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.offset <= off;
		req_ch.data <= d;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_word(logic [4:0] lo_off, logic [15:0] v);
		send(OP_WRITE, lo_off, v[7:0]);
		send(OP_WRITE, lo_off + 5'd1, v[15:8]);
	endtask

	task automatic read_result();
		send(OP_READ_LO, 5'($urandom), 8'($urandom));
		send(OP_READ_HI, 5'($urandom), 8'($urandom));
	endtask

	// Small counts keep most commands short; a few use the full byte.
	function automatic logic [7:0] pick_count();
		return ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'hffff;
			3: return 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic rand_sequence();
		logic [4:0] cmd;
		case ($urandom_range(0, 9))
			0: begin
				write_word(5'h00, pick_word());
				write_word(5'h02, pick_word());
				write_word(5'h04, pick_word());
				write_word(5'h06, pick_word());
				write_word(5'h08, pick_word());
				send(OP_WRITE, 5'h0a, 8'($urandom));
				send(OP_WRITE, OFF_CNT, pick_count());
				send(OP_WRITE, $urandom_range(0, 1) ? OFF_ROT : OFF_ROT_SUB, 8'($urandom));
			end
			1: begin
				write_word(5'h15, pick_word());
				write_word(5'h1a, pick_word());
				write_word(5'h0d, pick_word());
				write_word(5'h0f, pick_word());
				send(OP_WRITE, OFF_CNT, pick_count());
				cmd = $urandom_range(0, 1) ? OFF_DIV_AB : OFF_DIV_98;
				send(OP_WRITE, cmd, 8'($urandom));
			end
			2: begin
				write_word(5'h08, pick_word());
				write_word(5'h15, pick_word());
				write_word(5'h1a, pick_word());
				write_word(5'h0f, pick_word());
				send(OP_WRITE, 5'h0a, 8'($urandom));
				send(OP_WRITE, OFF_CNT, pick_count());
				send(OP_WRITE, OFF_WINDOW, 8'($urandom));
			end
			3: begin
				write_word(5'h00, pick_word());
				write_word(5'h02, pick_word());
				write_word(5'h04, pick_word());
				send(OP_WRITE, 5'h06, 8'($urandom));
				send(OP_WRITE, $urandom_range(0, 1) ? OFF_DIST_ABS : OFF_DIST, 8'($urandom));
			end
			4: begin
				send(OP_WRITE, OFF_CNT, pick_count());
				send(OP_WRITE, OFF_ROT_2ND, 8'($urandom));
			end
			5: send(OP_WRITE, 5'($urandom_range(5'h17, 5'h19)), 8'($urandom));
			6: send(op_t'($urandom_range(0, 3)), 5'($urandom), 8'($urandom));
			default: send(OP_WRITE, 5'($urandom_range(0, 5'h10)), 8'($urandom));
		endcase
		read_result();
	endtask

	initial begin
		logic [4:0] off;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: field extremes, status, the no-op offset, every command
		// and a division by zero.
		send(OP_STATUS, 5'h1f, 8'hff);
		write_word(5'h00, 16'h8000);
		write_word(5'h02, 16'h7fff);
		read_result();
		send(OP_WRITE, OFF_NOP, 8'hff);
		send(OP_WRITE, OFF_CNT, 8'h00);
		send(OP_WRITE, OFF_DIV_AB, 8'h00);
		read_result();
		send(OP_WRITE, OFF_ROT_SUB, 8'hff);
		send(OP_WRITE, OFF_ROT, 8'h80);
		send(OP_WRITE, OFF_ROT_2ND, 8'h00);
		send(OP_WRITE, OFF_DIV_98, 8'h00);
		send(OP_WRITE, OFF_WINDOW, 8'h7f);
		send(OP_WRITE, OFF_DIST_ABS, 8'hff);
		send(OP_WRITE, OFF_DIST, 8'h00);
		read_result();
		for (off = 5'h00; off != 5'h1f; off++)
			send(OP_WRITE, off, 8'($urandom));

		while (items_sent < 700)
			rand_sequence();

		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (50)
			@(posedge clk);
		if (errors == 0)
			$display("vector_math_box_core_tb passed");
		else
			$display("vector_math_box_core_tb failed");
		$finish;
	end
endmodule
